// ===== sv/espc_pkg.sv =====
// Shared types and constants of the escaped pathname syntax checker.
package espc_pkg;

  typedef logic signed [1:0] rule_t;

  localparam rule_t RULE_MUST     = 2'sb01;
  localparam rule_t RULE_MUST_NOT = 2'sb11;

  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_START_RULE   = 2'd0;
  localparam cfg_idx_t CFG_PATTERN_RULE = 2'd1;
  localparam cfg_idx_t CFG_END_RULE     = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DEL    = 8'd127;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESCAPE = 3'd1,
    PH_OCT2   = 3'd2,
    PH_OCT3   = 3'd3,
    PH_SLASH  = 3'd4
  } phase_e;

  typedef struct packed {
    rule_t start_rule;
    rule_t pattern_rule;
    rule_t end_rule;
  } rules_t;

  typedef struct packed {
    phase_e     phase;
    logic       at_start;
    logic [7:0] last_byte;
    logic [7:0] byte_before_escape;
    logic [4:0] octal_partial;
    logic       rep_open;
    logic       has_pattern;
    logic       failed;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:              PH_NORMAL,
    at_start:           1'b1,
    last_byte:          8'h00,
    byte_before_escape: 8'h00,
    octal_partial:      5'd0,
    rep_open:           1'b0,
    has_pattern:        1'b0,
    failed:             1'b0
  };

endpackage

// ===== sv/espc_char_if.sv =====
// Input channel: one pathname byte per item.
interface espc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// ===== sv/espc_res_if.sv =====
// Result channel: one verdict per terminated pathname.
interface espc_res_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

// ===== sv/espc_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface espc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/espc_cfg_regs.sv =====
// Configuration registers for the start, pattern and end rules.
module espc_cfg_regs
  import espc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  espc_cfg_if.sink    cfg_i,
  output rules_t      rules_o
);

  rules_t rules_q;

  assign cfg_i.ready = 1'b1;
  assign rules_o     = rules_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rules_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_START_RULE:   rules_q.start_rule   <= rule_t'(cfg_i.data);
        CFG_PATTERN_RULE: rules_q.pattern_rule <= rule_t'(cfg_i.data);
        CFG_END_RULE:     rules_q.end_rule     <= rule_t'(cfg_i.data);
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/espc_step.sv =====
// Per-byte next-state and verdict logic of the pathname scanner.
module espc_step
  import espc_pkg::*;
(
  input  scan_state_t cur_i,
  input  logic [7:0]  char_i,
  input  rules_t      rules_i,
  output scan_state_t nxt_o,
  output logic        term_o,
  output logic        verdict_o
);

  function automatic logic is_wildcard(input logic [7:0] c);
    return (c == 8'h24) || (c == 8'h2B) || (c == 8'h3F) || (c == 8'h2A) ||
           (c == 8'h40) || (c == 8'h78) || (c == 8'h58) || (c == 8'h61) ||
           (c == 8'h41) || (c == 8'h2D);
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  // Plain byte check: no slash inside a repetition, printable ASCII other than space only.
  function automatic logic plain_ok(input logic [7:0] c, input logic in_rep);
    return !(in_rep && (c == CH_SLASH)) && (c > CH_SPACE) && (c < CH_DEL);
  endfunction

  scan_state_t s;
  logic        ok;
  logic        fail_now;
  logic [7:0]  oct_val;
  logic        pat_forbid;

  always_comb begin
    s          = cur_i;
    ok         = 1'b1;
    oct_val    = {cur_i.octal_partial, char_i[2:0]};
    pat_forbid = (rules_i.pattern_rule == RULE_MUST_NOT);
    verdict_o  = 1'b0;
    term_o     = (char_i == CH_NUL);

    // start rule applies to the first byte of a pathname, terminator included
    fail_now = cur_i.failed;
    if (cur_i.at_start) begin
      if ((rules_i.start_rule == RULE_MUST) && (char_i != CH_SLASH)) fail_now = 1'b1;
      if ((rules_i.start_rule == RULE_MUST_NOT) && (char_i == CH_SLASH)) fail_now = 1'b1;
    end
    s.at_start = 1'b0;
    s.failed   = fail_now;

    if (term_o) begin
      verdict_o = !fail_now && (cur_i.phase == PH_NORMAL) && !cur_i.rep_open;
      if ((rules_i.end_rule == RULE_MUST) && (cur_i.last_byte != CH_SLASH)) verdict_o = 1'b0;
      if ((rules_i.end_rule == RULE_MUST_NOT) && (cur_i.last_byte == CH_SLASH))
        verdict_o = 1'b0;
      if ((rules_i.pattern_rule == RULE_MUST) && !cur_i.has_pattern) verdict_o = 1'b0;
      s = SCAN_RESET;
    end else begin
      if (!fail_now) begin
        case (cur_i.phase)
          PH_NORMAL: begin
            if (char_i == CH_BSLASH) begin
              s.byte_before_escape = cur_i.last_byte;
              s.phase              = PH_ESCAPE;
            end else begin
              ok = plain_ok(char_i, cur_i.rep_open);
            end
          end
          PH_ESCAPE: begin
            s.phase = PH_NORMAL;
            if (char_i == CH_BSLASH) begin
              ok = 1'b1;
            end else if (is_wildcard(char_i)) begin
              ok            = !pat_forbid;
              s.has_pattern = 1'b1;
            end else if (char_i == CH_LBRACE) begin
              ok            = (cur_i.byte_before_escape == CH_SLASH) && !pat_forbid;
              s.has_pattern = 1'b1;
              s.rep_open    = 1'b1;
            end else if (char_i == CH_RBRACE) begin
              ok         = cur_i.rep_open;
              s.rep_open = 1'b0;
              s.phase    = PH_SLASH;
            end else if ((char_i >= CH_ZERO) && (char_i <= CH_THREE)) begin
              s.octal_partial = {3'b000, char_i[1:0]};
              s.phase         = PH_OCT2;
            end else begin
              ok = 1'b0;
            end
          end
          PH_OCT2: begin
            ok              = is_octal(char_i);
            s.octal_partial = {cur_i.octal_partial[1:0], char_i[2:0]};
            s.phase         = PH_OCT3;
          end
          PH_OCT3: begin
            s.phase = PH_NORMAL;
            ok      = is_octal(char_i) && (oct_val != 8'h00) &&
                      ((oct_val <= CH_SPACE) || (oct_val >= CH_DEL));
          end
          PH_SLASH: begin
            s.phase = PH_NORMAL;
            ok      = (char_i == CH_SLASH) && plain_ok(char_i, cur_i.rep_open);
          end
          default: begin
            ok = 1'b0;
          end
        endcase
      end
      s.failed    = fail_now || !ok;
      s.last_byte = char_i;
    end
    nxt_o = s;
  end

endmodule

// ===== sv/escaped_path_syntax_checker_core.sv =====
// Escaped pathname syntax checker: one byte per item, one verdict per pathname.
// A terminating zero byte is held in the input register, then its verdict is loaded into the result register.
// Throughput: one byte per clock while no terminator stalls; the scan state updates once per byte.
// Back pressure on the result side stalls only when a terminator meets a full result reg.
// Reset: all rules read as "either", scan state returns to the start of a pathname.
module escaped_path_syntax_checker_core
  import espc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  espc_char_if.sink  char_i,
  espc_res_if.source res_o,
  espc_cfg_if.sink   cfg_i
);

  // Configuration registers
  rules_t rules;

  espc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .rules_o (rules)
  );

  // Input register: holds one byte ahead of the scanner
  logic       in_vld_q;
  logic [7:0] in_char_q;

  // Scanner state, advanced once per byte
  scan_state_t state_q;
  scan_state_t state_d;
  logic        term;
  logic        verdict;

  // Result register
  logic out_vld_q;
  logic out_res_q;

  logic s1_go;

  espc_step u_step (
    .cur_i     (state_q),
    .char_i    (in_char_q),
    .rules_i   (rules),
    .nxt_o     (state_d),
    .term_o    (term),
    .verdict_o (verdict)
  );

  // A non-terminator byte always advances; a terminator needs room in the result register.
  assign s1_go = in_vld_q && (!term || !out_vld_q || res_o.ready);

  // Take a new byte whenever the input register is empty or drains this cycle.
  assign char_i.ready = !in_vld_q || s1_go;

  assign res_o.valid     = out_vld_q;
  assign res_o.valid_res = out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      state_q   <= SCAN_RESET;
      out_vld_q <= 1'b0;
    end else begin
      // input register: load on accept, drop once consumed
      if (char_i.valid && char_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (s1_go) begin
        in_vld_q <= 1'b0;
      end

      // advance the scanner
      if (s1_go) begin
        state_q <= state_d;
      end

      // result register: load on terminator, clear when taken
      if (s1_go && term) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      in_char_q <= char_i.char_code;
    end
    if (s1_go && term) begin
      out_res_q <= verdict;
    end
  end

endmodule
